[rtl/srsd_pkg.sv]
`timescale 1ns / 1ps

package srsd_pkg;

    localparam int NUM_SETS    = 65;
    localparam int MAX_ENTRIES = 16;
    localparam int SET_W       = 7;
    localparam int POS_W       = 4;
    localparam int CNT_W       = 5;
    localparam int DELTA_W     = 24;
    localparam int DRPS_W      = 18;
    localparam int FLAGS_W     = 17;
    localparam int ELEM_W      = 16;
    localparam int ADDR_W      = 12;
    localparam int MEM_DEPTH   = NUM_SETS * 2 * MAX_ENTRIES;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_INDEX = 2'd1;
    localparam logic [1:0] ST_REF   = 2'd2;
    localparam logic [1:0] ST_COUNT = 2'd3;

    typedef enum logic [3:0] {
        PH_IDLE, PH_FLAG, PH_DIDX, PH_SIGN, PH_ABS, PH_PUSED, PH_PUSEDELTA,
        PH_NNEG, PH_NPOS, PH_S0D, PH_S0U, PH_S1D, PH_S1U
    } phase_t;

    typedef enum logic [2:0] {
        CMD_ERR, CMD_WDELTA, CMD_WUSED, CMD_FIN_EXPL, CMD_FIN_PRED
    } cmd_kind_t;

    typedef enum logic [3:0] {
        BK_IDLE, BK_ERR, BK_EMPTY, BK_CUPD, BK_WALK_RD, BK_WALK_EV,
        BK_SCAN_RD, BK_SCAN_EV
    } back_state_t;

    typedef struct packed {
        cmd_kind_t                   kind;
        logic [1:0]                  status;
        logic [SET_W-1:0]            set_idx;
        logic [SET_W-1:0]            ref_idx;
        logic                        list;
        logic [POS_W-1:0]            pos;
        logic signed [DELTA_W-1:0]   delta;
        logic                        used;
        logic                        fin;
        logic [CNT_W-1:0]            neg_cnt;
        logic [CNT_W-1:0]            pos_cnt;
        logic signed [DRPS_W-1:0]    drps;
        logic [FLAGS_W-1:0]          used_flags;
        logic [FLAGS_W-1:0]          use_flags;
    } cmd_t;

    typedef struct packed {
        logic             valid;
        logic [SET_W-1:0] set_idx;
        logic [CNT_W-1:0] neg_cnt;
        logic [CNT_W-1:0] pos_cnt;
    } cnt_wr_t;

    typedef struct packed {
        logic [1:0]                status;
        logic                      list_sel;
        logic [POS_W-1:0]          entry_pos;
        logic signed [DELTA_W-1:0] delta_poc;
        logic                      used_by_current;
        logic                      entry_valid;
        logic [5:0]                used_count;
        logic                      last;
    } res_t;

    // clamp to the signed 24-bit range
    function automatic logic signed [DELTA_W-1:0] sat24(input logic signed [DELTA_W+1:0] v);
        logic signed [DELTA_W-1:0] r;
        if (v > 26'sd8388607) begin
            r = 24'sh7FFFFF;
        end else if (v < -26'sd8388608) begin
            r = 24'sh800000;
        end else begin
            r = v[DELTA_W-1:0];
        end
        return r;
    endfunction

endpackage

[rtl/srsd_cmd_fifo.sv]
`timescale 1ns / 1ps

module srsd_cmd_fifo import srsd_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_data,
    output logic full,
    input  logic rd_en,
    output cmd_t rd_data,
    output logic empty
);

    cmd_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_wr, do_rd;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign rd_data = q_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    // pointer and fill update
    always_comb
    begin
        wr_ptr_next = do_wr ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            q_reg[wr_ptr_reg] <= wr_data;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("command queue fill out of range");
    a_fill_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (do_wr && !do_rd) |=> !empty)
        else $error("command queue lost a beat");
    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("command queue pointers disagree");
`endif

endmodule

[rtl/srsd_front.sv]
`timescale 1ns / 1ps

module srsd_front import srsd_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic                start_req,
    input  logic [SET_W-1:0]    rps_index,
    input  logic [ELEM_W-1:0]   element,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [SET_W-1:0]    sets_in_parameter_set,
    output cmd_t                cmd,
    output logic                cmd_push,
    input  logic                q_full,
    input  logic                back_idle,
    input  cnt_wr_t             cnt_wr
);

    phase_t                    phase_reg, phase_next;
    logic [SET_W-1:0]          cur_reg, cur_next;
    logic [SET_W-1:0]          ref_reg, ref_next;
    logic                      sign_reg, sign_next;
    logic signed [DRPS_W-1:0]  drps_reg, drps_next;
    logic [CNT_W-1:0]          ctr_reg, ctr_next;
    logic [FLAGS_W-1:0]        uf_reg, uf_next;
    logic [FLAGS_W-1:0]        udf_reg, udf_next;
    logic [CNT_W-1:0]          neg_reg, neg_next;
    logic [CNT_W-1:0]          pos_reg, pos_next;
    logic signed [DELTA_W-1:0] prev_reg, prev_next;
    logic [SET_W-1:0]          sets_reg;

    logic [2*CNT_W-1:0]        cnt_mem [0:NUM_SETS-1];
    logic [NUM_SETS-1:0]       cnt_vld_reg;
    logic [2*CNT_W-1:0]        rd_cnt_reg;
    logic                      rd_vld_reg;

    logic                      accept, start_ok, live, bit_v, rd_en;
    phase_t                    eff_phase;
    logic [SET_W-1:0]          eff_cur;
    logic [CNT_W-1:0]          eff_ctr, eff_neg, ctr_inc, ref_neg, ref_pos;
    logic [FLAGS_W-1:0]        eff_uf, eff_udf, mask, uf_upd, udf_upd;
    logic [5:0]                flag_total;
    logic                      flag_done;
    logic [ELEM_W:0]           el_p1;
    logic [ELEM_W:0]           npos_sum;
    logic [DRPS_W-1:0]         mag;
    logic signed [DELTA_W-1:0] base;
    logic [DELTA_W+1:0]        base26, el26, val26;
    logic signed [DELTA_W-1:0] expl_sat;

    assign cfg_ready = 1'b1;
    assign full      = q_full || (phase_reg == PH_ABS && !back_idle);
    assign accept    = push && !full;
    assign bit_v     = element[0];

    // effective state: a start beat reopens parsing
    always_comb
    begin
        start_ok  = start_req && ({1'b0, rps_index} < 8'(NUM_SETS));
        live      = start_req ? start_ok : (phase_reg != PH_IDLE);
        eff_phase = start_req ? ((rps_index != '0) ? PH_FLAG : PH_NNEG) : phase_reg;
        eff_cur   = start_req ? rps_index : cur_reg;
        eff_ctr   = start_req ? '0 : ctr_reg;
        eff_uf    = start_req ? '0 : uf_reg;
        eff_udf   = start_req ? '0 : udf_reg;
        eff_neg   = start_req ? '0 : neg_reg;
        ref_neg   = rd_vld_reg ? rd_cnt_reg[2*CNT_W-1:CNT_W] : '0;
        ref_pos   = rd_vld_reg ? rd_cnt_reg[CNT_W-1:0] : '0;
        flag_total = {1'b0, ref_neg} + {1'b0, ref_pos} + 6'd1;
        ctr_inc   = eff_ctr + 5'd1;
        flag_done = ({1'b0, ctr_inc} >= flag_total);
        mask      = FLAGS_W'(1) << eff_ctr;
        uf_upd    = eff_uf | ((eff_phase == PH_PUSED && bit_v) ? mask : '0);
        udf_upd   = eff_udf | (bit_v ? mask : '0);
        el_p1     = {1'b0, element} + 17'd1;
        npos_sum  = {12'd0, eff_neg} + {1'b0, element};
        mag       = {1'b0, el_p1};
        base      = (eff_ctr == '0) ? '0 : prev_reg;
        base26    = {{2{base[DELTA_W-1]}}, base};
        el26      = {9'd0, el_p1};
        val26     = (eff_phase == PH_S1D) ? (base26 + el26) : (base26 - el26);
        expl_sat  = sat24($signed(val26));
    end

    // parse sequencer next state
    always_comb
    begin
        phase_next = phase_reg;
        cur_next   = cur_reg;
        ref_next   = ref_reg;
        sign_next  = sign_reg;
        drps_next  = drps_reg;
        ctr_next   = ctr_reg;
        uf_next    = uf_reg;
        udf_next   = udf_reg;
        neg_next   = neg_reg;
        pos_next   = pos_reg;
        prev_next  = prev_reg;
        if (accept && start_req && !start_ok)
        begin
            phase_next = PH_IDLE;
        end
        else if (accept && live)
        begin
            cur_next = eff_cur;
            ctr_next = eff_ctr;
            uf_next  = eff_uf;
            udf_next = eff_udf;
            neg_next = eff_neg;
            unique case (eff_phase)
                PH_FLAG:
                begin
                    if (!bit_v)
                        phase_next = PH_NNEG;
                    else if (eff_cur == sets_reg)
                        phase_next = PH_DIDX;
                    else
                    begin
                        ref_next   = eff_cur - 7'd1;
                        phase_next = PH_SIGN;
                    end
                end
                PH_DIDX:
                begin
                    if (element >= {9'd0, eff_cur})
                        phase_next = PH_IDLE;
                    else
                    begin
                        ref_next   = eff_cur - 7'd1 - element[SET_W-1:0];
                        phase_next = PH_SIGN;
                    end
                end
                PH_SIGN:
                begin
                    sign_next  = bit_v;
                    phase_next = PH_ABS;
                end
                PH_ABS:
                begin
                    drps_next  = sign_reg ? $signed(18'd0 - mag) : $signed(mag);
                    ctr_next   = '0;
                    phase_next = PH_PUSED;
                end
                PH_PUSED, PH_PUSEDELTA:
                begin
                    if (eff_phase == PH_PUSED && !bit_v)
                        phase_next = PH_PUSEDELTA;
                    else
                    begin
                        uf_next  = uf_upd;
                        udf_next = udf_upd;
                        if (flag_done)
                            phase_next = PH_IDLE;
                        else
                        begin
                            ctr_next   = ctr_inc;
                            phase_next = PH_PUSED;
                        end
                    end
                end
                PH_NNEG:
                begin
                    if (element > 16'(MAX_ENTRIES))
                        phase_next = PH_IDLE;
                    else
                    begin
                        neg_next   = element[CNT_W-1:0];
                        phase_next = PH_NPOS;
                    end
                end
                PH_NPOS:
                begin
                    if (npos_sum > 17'(MAX_ENTRIES))
                        phase_next = PH_IDLE;
                    else
                    begin
                        pos_next = element[CNT_W-1:0];
                        ctr_next = '0;
                        if (eff_neg != '0)
                            phase_next = PH_S0D;
                        else if (element != '0)
                            phase_next = PH_S1D;
                        else
                            phase_next = PH_IDLE;
                    end
                end
                PH_S0D, PH_S1D:
                begin
                    prev_next  = expl_sat;
                    phase_next = (eff_phase == PH_S0D) ? PH_S0U : PH_S1U;
                end
                PH_S0U:
                begin
                    if (ctr_inc < eff_neg)
                    begin
                        ctr_next   = ctr_inc;
                        phase_next = PH_S0D;
                    end
                    else
                    begin
                        ctr_next   = '0;
                        phase_next = (pos_reg != '0) ? PH_S1D : PH_IDLE;
                    end
                end
                PH_S1U:
                begin
                    if (ctr_inc < pos_reg)
                    begin
                        ctr_next   = ctr_inc;
                        phase_next = PH_S1D;
                    end
                    else
                        phase_next = PH_IDLE;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // command to the back part
    always_comb
    begin
        cmd            = '0;
        cmd.kind       = CMD_ERR;
        cmd.set_idx    = eff_cur;
        cmd.ref_idx    = ref_reg;
        cmd.pos        = eff_ctr[POS_W-1:0];
        cmd.delta      = expl_sat;
        cmd.used       = bit_v;
        cmd.neg_cnt    = eff_neg;
        cmd.pos_cnt    = pos_reg;
        cmd.drps       = drps_reg;
        cmd.used_flags = uf_upd;
        cmd.use_flags  = udf_upd;
        cmd_push       = 1'b0;
        if (accept && start_req && !start_ok)
        begin
            cmd_push   = 1'b1;
            cmd.status = ST_INDEX;
        end
        else if (accept && live)
        begin
            unique case (eff_phase)
                PH_DIDX:
                begin
                    cmd_push   = (element >= {9'd0, eff_cur});
                    cmd.status = ST_REF;
                end
                PH_PUSED, PH_PUSEDELTA:
                begin
                    cmd_push    = flag_done && (eff_phase == PH_PUSEDELTA || bit_v);
                    cmd.kind    = CMD_FIN_PRED;
                    cmd.neg_cnt = ref_neg;
                    cmd.pos_cnt = ref_pos;
                end
                PH_NNEG:
                begin
                    cmd_push   = (element > 16'(MAX_ENTRIES));
                    cmd.status = ST_COUNT;
                end
                PH_NPOS:
                begin
                    cmd_push    = 1'b1;
                    cmd.pos_cnt = element[CNT_W-1:0];
                    if (npos_sum > 17'(MAX_ENTRIES))
                        cmd.status = ST_COUNT;
                    else
                    begin
                        cmd.kind = CMD_FIN_EXPL;
                        cmd_push = (eff_neg == '0) && (element == '0);
                    end
                end
                PH_S0D, PH_S1D:
                begin
                    cmd_push = 1'b1;
                    cmd.kind = CMD_WDELTA;
                    cmd.list = (eff_phase == PH_S1D);
                end
                PH_S0U:
                begin
                    cmd_push = 1'b1;
                    cmd.kind = CMD_WUSED;
                    cmd.list = 1'b0;
                    cmd.fin  = !(ctr_inc < eff_neg) && (pos_reg == '0);
                end
                PH_S1U:
                begin
                    cmd_push = 1'b1;
                    cmd.kind = CMD_WUSED;
                    cmd.list = 1'b1;
                    cmd.fin  = !(ctr_inc < pos_reg);
                end
                default:
                begin
                    cmd_push = 1'b0;
                end
            endcase
        end
    end

    assign rd_en = accept && live && (eff_phase == PH_ABS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            cur_reg     <= '0;
            ref_reg     <= '0;
            sign_reg    <= 1'b0;
            drps_reg    <= '0;
            ctr_reg     <= '0;
            uf_reg      <= '0;
            udf_reg     <= '0;
            neg_reg     <= '0;
            pos_reg     <= '0;
            prev_reg    <= '0;
            sets_reg    <= '0;
            cnt_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            cur_reg   <= cur_next;
            ref_reg   <= ref_next;
            sign_reg  <= sign_next;
            drps_reg  <= drps_next;
            ctr_reg   <= ctr_next;
            uf_reg    <= uf_next;
            udf_reg   <= udf_next;
            neg_reg   <= neg_next;
            pos_reg   <= pos_next;
            prev_reg  <= prev_next;
            if (cfg_valid)
                sets_reg <= sets_in_parameter_set;
            if (cnt_wr.valid)
                cnt_vld_reg[cnt_wr.set_idx] <= 1'b1;
            if (rd_en)
                rd_vld_reg <= cnt_vld_reg[ref_reg];
        end
    end

    // per-set list counts, written by the back part
    always_ff @(posedge clk)
    begin
        if (cnt_wr.valid)
            cnt_mem[cnt_wr.set_idx] <= {cnt_wr.neg_cnt, cnt_wr.pos_cnt};
        if (rd_en)
            rd_cnt_reg <= cnt_mem[ref_reg];
    end

`ifndef NO_ASSERTIONS
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> !q_full)
        else $error("command pushed into a full queue");
    a_abs_idle: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> back_idle)
        else $error("reference counts read while back part busy");
    a_ctr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctr_reg <= 5'd16)
        else $error("element counter out of range");
`endif

endmodule

[rtl/srsd_back.sv]
`timescale 1ns / 1ps

module srsd_back import srsd_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  cmd_t    cmd,
    input  logic    cmd_empty,
    output logic    cmd_pop,
    output logic    idle,
    output cnt_wr_t cnt_wr,
    output res_t    res,
    output logic    empty,
    input  logic    pop
);

    back_state_t      state_reg, state_next;
    cmd_t             c_reg, c_next;
    logic             pass_reg, pass_next;
    logic [2:0]       seg_reg, seg_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] n0_reg, n0_next, n1_reg, n1_next;
    logic [CNT_W-1:0] cn_reg, cn_next, cp_reg, cp_next;
    logic [CNT_W-1:0] ucnt_reg, ucnt_next, k_reg, k_next;
    logic [1:0]       err_reg, err_next;

    logic signed [DELTA_W-1:0] delta_mem [0:MEM_DEPTH-1];
    logic                      used_mem  [0:MEM_DEPTH-1];
    logic signed [DELTA_W-1:0] rd_delta_reg;
    logic                      rd_used_reg;

    logic                      we_delta, we_used, re;
    logic [ADDR_W-1:0]         waddr, raddr;
    logic signed [DELTA_W-1:0] wdelta;
    logic                      wused;

    res_t       q_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] qc_reg;
    logic       out_full, out_push;
    res_t       out_data;

    logic [CNT_W-1:0]   rn, rp, walk_len, scan_len, wpos, bidx;
    logic               dseg, nseg, rlist, flag_bit, keep;
    logic [DELTA_W+1:0] dp;
    logic [5:0]         ncount;

    assign idle     = (state_reg == BK_IDLE);
    assign out_full = (qc_reg == 2'd2);
    assign empty    = (qc_reg == 2'd0);
    assign res      = q_reg[rp_reg];

    // derivation walk: segment lengths, positions and flag bits
    always_comb
    begin
        rn    = c_reg.neg_cnt;
        rp    = c_reg.pos_cnt;
        dseg  = (seg_reg == 3'd1) || (seg_reg == 3'd4);
        nseg  = (seg_reg < 3'd3);
        rlist = (seg_reg == 3'd0) || (seg_reg == 3'd5);
        case (seg_reg)
            3'd0:    begin walk_len = rp;   wpos = rp - 5'd1 - idx_reg; bidx = rn + wpos; end
            3'd1:    begin walk_len = 5'd1; wpos = '0;                  bidx = rn + rp;   end
            3'd2:    begin walk_len = rn;   wpos = idx_reg;             bidx = idx_reg;   end
            3'd3:    begin walk_len = rn;   wpos = rn - 5'd1 - idx_reg; bidx = wpos;      end
            3'd4:    begin walk_len = 5'd1; wpos = '0;                  bidx = rn + rp;   end
            default: begin walk_len = rp;   wpos = idx_reg;             bidx = rn + idx_reg; end
        endcase
        dp = (dseg ? '0 : {{2{rd_delta_reg[DELTA_W-1]}}, rd_delta_reg})
             + {{8{c_reg.drps[DRPS_W-1]}}, c_reg.drps};
        flag_bit = c_reg.use_flags[bidx];
        keep     = flag_bit && (nseg ? dp[DELTA_W+1] : (!dp[DELTA_W+1] && dp != '0));
        scan_len = seg_reg[0] ? cp_reg : cn_reg;
        ncount   = {1'b0, n0_reg} + {1'b0, n1_reg};
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        c_next     = c_reg;
        pass_next  = pass_reg;
        seg_next   = seg_reg;
        idx_next   = idx_reg;
        n0_next    = n0_reg;
        n1_next    = n1_reg;
        cn_next    = cn_reg;
        cp_next    = cp_reg;
        ucnt_next  = ucnt_reg;
        k_next     = k_reg;
        err_next   = err_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!cmd_empty)
                begin
                    c_next = cmd;
                    case (cmd.kind)
                        CMD_ERR:
                        begin
                            err_next   = cmd.status;
                            state_next = BK_ERR;
                        end
                        CMD_WUSED, CMD_FIN_EXPL:
                        begin
                            cn_next = cmd.neg_cnt;
                            cp_next = cmd.pos_cnt;
                            if (cmd.kind == CMD_FIN_EXPL || cmd.fin)
                                state_next = BK_CUPD;
                        end
                        CMD_FIN_PRED:
                        begin
                            pass_next  = 1'b0;
                            seg_next   = '0;
                            idx_next   = '0;
                            n0_next    = '0;
                            n1_next    = '0;
                            state_next = BK_WALK_RD;
                        end
                        default:
                        begin
                            state_next = BK_IDLE;
                        end
                    endcase
                end
            end
            BK_ERR, BK_EMPTY:
            begin
                if (!out_full)
                    state_next = BK_IDLE;
            end
            BK_CUPD:
            begin
                seg_next   = '0;
                idx_next   = '0;
                pass_next  = 1'b0;
                ucnt_next  = '0;
                k_next     = '0;
                state_next = (cn_reg == '0 && cp_reg == '0) ? BK_EMPTY : BK_SCAN_RD;
            end
            BK_WALK_RD:
            begin
                if (idx_reg >= walk_len)
                begin
                    idx_next = '0;
                    if (seg_reg == 3'd5)
                    begin
                        seg_next = '0;
                        if (pass_reg)
                        begin
                            cn_next    = n0_reg;
                            cp_next    = n1_reg;
                            state_next = BK_CUPD;
                        end
                        else if (ncount > 6'(MAX_ENTRIES))
                        begin
                            err_next   = ST_COUNT;
                            state_next = BK_ERR;
                        end
                        else
                        begin
                            pass_next = 1'b1;
                            n0_next   = '0;
                            n1_next   = '0;
                        end
                    end
                    else
                        seg_next = seg_reg + 3'd1;
                end
                else
                    state_next = BK_WALK_EV;
            end
            BK_WALK_EV:
            begin
                if (keep)
                begin
                    if (nseg)
                        n0_next = n0_reg + 5'd1;
                    else
                        n1_next = n1_reg + 5'd1;
                end
                idx_next   = idx_reg + 5'd1;
                state_next = BK_WALK_RD;
            end
            BK_SCAN_RD:
            begin
                if (idx_reg >= scan_len)
                begin
                    idx_next = '0;
                    if (seg_reg[0])
                    begin
                        seg_next = '0;
                        if (pass_reg)
                            state_next = BK_IDLE;
                        else
                            pass_next = 1'b1;
                    end
                    else
                        seg_next = 3'd1;
                end
                else
                    state_next = BK_SCAN_EV;
            end
            BK_SCAN_EV:
            begin
                if (!pass_reg)
                begin
                    ucnt_next  = ucnt_reg + {4'd0, rd_used_reg};
                    idx_next   = idx_reg + 5'd1;
                    state_next = BK_SCAN_RD;
                end
                else if (!out_full)
                begin
                    k_next     = k_reg + 5'd1;
                    idx_next   = idx_reg + 5'd1;
                    state_next = BK_SCAN_RD;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // memory ports, count update and result beats
    always_comb
    begin
        cmd_pop  = 1'b0;
        we_delta = 1'b0;
        we_used  = 1'b0;
        waddr    = {cmd.set_idx, cmd.list, cmd.pos};
        wdelta   = cmd.delta;
        wused    = cmd.used;
        re       = 1'b0;
        raddr    = {c_reg.ref_idx, rlist, wpos[POS_W-1:0]};
        cnt_wr   = '{valid: 1'b0, set_idx: c_reg.set_idx, neg_cnt: cn_reg, pos_cnt: cp_reg};
        out_push = 1'b0;
        out_data = '0;
        unique case (state_reg)
            BK_IDLE:
            begin
                cmd_pop  = !cmd_empty;
                we_delta = !cmd_empty && (cmd.kind == CMD_WDELTA);
                we_used  = !cmd_empty && (cmd.kind == CMD_WUSED);
            end
            BK_ERR:
            begin
                out_push        = !out_full;
                out_data.status = err_reg;
                out_data.last   = 1'b1;
            end
            BK_EMPTY:
            begin
                out_push      = !out_full;
                out_data.last = 1'b1;
            end
            BK_CUPD:
            begin
                cnt_wr.valid = 1'b1;
            end
            BK_WALK_RD:
            begin
                re = 1'b1;
            end
            BK_WALK_EV:
            begin
                we_delta = pass_reg && keep;
                we_used  = pass_reg && keep;
                waddr    = {c_reg.set_idx, !nseg, nseg ? n0_reg[POS_W-1:0] : n1_reg[POS_W-1:0]};
                wdelta   = sat24($signed(dp));
                wused    = c_reg.used_flags[bidx];
            end
            BK_SCAN_RD:
            begin
                re    = 1'b1;
                raddr = {c_reg.set_idx, seg_reg[0], idx_reg[POS_W-1:0]};
            end
            BK_SCAN_EV:
            begin
                out_push                 = pass_reg && !out_full;
                out_data.status          = ST_OK;
                out_data.list_sel        = seg_reg[0];
                out_data.entry_pos       = idx_reg[POS_W-1:0];
                out_data.delta_poc       = rd_delta_reg;
                out_data.used_by_current = rd_used_reg;
                out_data.entry_valid     = 1'b1;
                out_data.used_count      = {1'b0, ucnt_reg};
                out_data.last            = ({1'b0, k_reg} + 6'd1 == {1'b0, cn_reg} + {1'b0, cp_reg});
            end
            default:
            begin
                re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            pass_reg  <= 1'b0;
            seg_reg   <= '0;
            idx_reg   <= '0;
            n0_reg    <= '0;
            n1_reg    <= '0;
            cn_reg    <= '0;
            cp_reg    <= '0;
            ucnt_reg  <= '0;
            k_reg     <= '0;
            err_reg   <= ST_OK;
            wp_reg    <= 1'b0;
            rp_reg    <= 1'b0;
            qc_reg    <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
            seg_reg   <= seg_next;
            idx_reg   <= idx_next;
            n0_reg    <= n0_next;
            n1_reg    <= n1_next;
            cn_reg    <= cn_next;
            cp_reg    <= cp_next;
            ucnt_reg  <= ucnt_next;
            k_reg     <= k_next;
            err_reg   <= err_next;
            if (out_push)
                wp_reg <= !wp_reg;
            if (pop && !empty)
                rp_reg <= !rp_reg;
            qc_reg <= qc_reg + {1'b0, out_push} - {1'b0, pop && !empty};
        end
    end

    // latched command and result queue payload
    always_ff @(posedge clk)
    begin
        c_reg <= c_next;
        if (out_push)
            q_reg[wp_reg] <= out_data;
    end

    // entry store
    always_ff @(posedge clk)
    begin
        if (we_delta)
            delta_mem[waddr] <= wdelta;
        if (we_used)
            used_mem[waddr] <= wused;
        if (re)
        begin
            rd_delta_reg <= delta_mem[raddr];
            rd_used_reg  <= used_mem[raddr];
        end
    end

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_wr.valid |-> ({1'b0, cnt_wr.neg_cnt} + {1'b0, cnt_wr.pos_cnt} <= 6'd16))
        else $error("stored counts exceed the entry limit");
    a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> !out_full)
        else $error("result pushed into a full queue");
    a_wr_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_WALK_EV && pass_reg && keep) |-> (ncount < 6'd16))
        else $error("derived entry beyond list capacity");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> (state_reg == BK_IDLE))
        else $error("command taken while busy");
`endif

endmodule

[rtl/short_term_ref_set_derivation.sv]
// one syntax element per beat; after the beat that closes a set, the set's results follow
// the derivation walk for a predicted set (two passes over up to 16 reference entries and
// the set delta itself) and two scans of the set, all through the entry store, which serves
// one read or one write at a time
// the beat carrying the delta magnitude waits until the derivation of the previous set ends
// reset is asynchronous, active low; it clears control state and marks all counts empty
`timescale 1ns / 1ps

module short_term_ref_set_derivation import srsd_pkg::*; (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic                      start_req,
    input  logic [SET_W-1:0]          rps_index,
    input  logic [ELEM_W-1:0]         element,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [SET_W-1:0]          sets_in_parameter_set,
    output logic                      empty,
    input  logic                      pop,
    output logic [1:0]                status,
    output logic                      list_sel,
    output logic [POS_W-1:0]          entry_pos,
    output logic signed [DELTA_W-1:0] delta_poc,
    output logic                      used_by_current,
    output logic                      entry_valid,
    output logic [5:0]                used_count,
    output logic                      last
);

    cmd_t    f_cmd, q_cmd;
    logic    f_push, q_full, q_empty, q_pop, b_idle;
    cnt_wr_t cnt_wr;
    res_t    res;

    srsd_front u_front (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .push                  (push),
        .full                  (full),
        .start_req             (start_req),
        .rps_index             (rps_index),
        .element               (element),
        .cfg_valid             (cfg_valid),
        .cfg_ready             (cfg_ready),
        .sets_in_parameter_set (sets_in_parameter_set),
        .cmd                   (f_cmd),
        .cmd_push              (f_push),
        .q_full                (q_full),
        .back_idle             (b_idle && q_empty),
        .cnt_wr                (cnt_wr)
    );

    srsd_cmd_fifo u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (f_push),
        .wr_data (f_cmd),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_cmd),
        .empty   (q_empty)
    );

    srsd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (q_cmd),
        .cmd_empty (q_empty),
        .cmd_pop   (q_pop),
        .idle      (b_idle),
        .cnt_wr    (cnt_wr),
        .res       (res),
        .empty     (empty),
        .pop       (pop)
    );

    // result fields
    assign status          = res.status;
    assign list_sel        = res.list_sel;
    assign entry_pos       = res.entry_pos;
    assign delta_poc       = res.delta_poc;
    assign used_by_current = res.used_by_current;
    assign entry_valid     = res.entry_valid;
    assign used_count      = res.used_count;
    assign last            = res.last;

endmodule
